// File: hdl/ewma_pkg.sv
`default_nettype none

package ewma_pkg;

   localparam int NUM_TYPES = 4;
   localparam int TYPE_W    = $clog2(NUM_TYPES);
   localparam int PWR_W     = 20;
   localparam int PCT_W     = 7;
   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 2;

   // a*cur + (100-a)*prev stays below 2^27
   localparam int PROD_W = PWR_W + PCT_W;

   // floor(x/100) = (x * RECIP) >> RECIP_SHIFT, exact for x < 2^27
   localparam int                 RECIP_W     = 28;
   localparam int                 RECIP_SHIFT = 34;
   localparam logic [RECIP_W-1:0] RECIP       = 28'd171798692;
   localparam int                 QPROD_W     = PROD_W + RECIP_W;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_POWER  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ENABLE = 2'd3;

   localparam logic [PCT_W-1:0] ALPHA_RESET = 7'd50;
   localparam logic [PCT_W-1:0] DELTA_RESET = 7'd10;

   typedef struct packed {
      logic [PWR_W-1:0] ewma;
      logic [PWR_W-1:0] used;
   } hist_type;

   typedef struct packed {
      logic [TYPE_W-1:0] ch;
      logic [PWR_W-1:0]  cur;
      logic [PWR_W-1:0]  mid;
      logic [PWR_W-1:0]  span;
   } s1_type;

   typedef struct packed {
      logic [TYPE_W-1:0] ch;
      logic [PWR_W-1:0]  cur;
      logic [PWR_W-1:0]  prev_used;
      logic [PWR_W-1:0]  prev_ewma;
      logic              hist_valid;
      logic [PROD_W-1:0] pa;
      logic [PROD_W-1:0] pb;
      logic [PROD_W-1:0] pd;
   } s2_type;

   typedef struct packed {
      logic [TYPE_W-1:0] ch;
      logic [PWR_W-1:0]  cur;
      logic [PWR_W-1:0]  prev_used;
      logic [PWR_W-1:0]  prev_ewma;
      logic              hist_valid;
      logic [PROD_W-1:0] sum;
      logic [PROD_W-1:0] pd;
      logic              ge;
      logic [PWR_W-1:0]  diff;
   } s3_type;

   typedef struct packed {
      logic [TYPE_W-1:0] ch;
      logic [PWR_W-1:0]  cur;
      logic [PWR_W-1:0]  prev_used;
      logic [PWR_W-1:0]  prev_ewma;
      logic              hist_valid;
      logic              ge;
      logic [PWR_W-1:0]  diff;
      logic [PWR_W-1:0]  ewma;
      logic [PWR_W-1:0]  chg;
   } s4_type;

   function automatic logic [PCT_W-1:0] sat100(input logic [PCT_W-1:0] v);
      return (v > PCT_FULL) ? PCT_FULL : v;
   endfunction

endpackage

`default_nettype wire

// File: hdl/ewma_power_filter_slew_limited.sv
// Pipeline: an accepted req item goes through read, multiply, add, reciprocal multiply
//    and decide steps to rsp_valid; the result then sits in the rsp register until taken.
// Throughput: one item per cycle unless rsp_stall holds the output or an item for the
//    same channel is in flight; a new one waits until that item writes the history memory.
// Reset: clears the pipeline and the per-channel history flags and loads the register
//    defaults; the history memory itself is not cleared, its flags mask stale entries.
`default_nettype none

module ewma_power_filter_slew_limited (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [ewma_pkg::TYPE_W-1:0]          req_control_type,
   input  wire  [ewma_pkg::PWR_W-1:0]           req_current_power,
   input  wire  [ewma_pkg::PWR_W-1:0]           req_max_limit,
   input  wire  [ewma_pkg::PWR_W-1:0]           req_min_limit,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [ewma_pkg::PWR_W-1:0]           rsp_power_used,
   input  wire                                  csr_write_enable,
   input  wire  [ewma_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [ewma_pkg::CSR_W-1:0]           csr_write_data
);

   // configuration registers
   logic [ewma_pkg::PCT_W-1:0] alpha_ff;
   logic [ewma_pkg::PCT_W-1:0] delta_ff;
   logic [ewma_pkg::PWR_W-1:0] seed_power_ff;
   logic                       seed_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff       <= ewma_pkg::ALPHA_RESET;
         delta_ff       <= ewma_pkg::DELTA_RESET;
         seed_power_ff  <= '0;
         seed_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ewma_pkg::CSR_ALPHA:       alpha_ff       <= csr_write_data[ewma_pkg::PCT_W-1:0];
            ewma_pkg::CSR_DELTA:       delta_ff       <= csr_write_data[ewma_pkg::PCT_W-1:0];
            ewma_pkg::CSR_SEED_POWER:  seed_power_ff  <= csr_write_data[ewma_pkg::PWR_W-1:0];
            ewma_pkg::CSR_SEED_ENABLE: seed_enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   logic [ewma_pkg::PCT_W-1:0] alpha_sat;
   logic [ewma_pkg::PCT_W-1:0] delta_sat;
   assign alpha_sat = ewma_pkg::sat100(alpha_ff);
   assign delta_sat = ewma_pkg::sat100(delta_ff);

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, v4_in, rsp_valid_in;
   logic ready1, ready2, ready3, ready4, ready_out;
   logic hazard, accept, wr_en;

   ewma_pkg::s1_type s1_ff, s1_in;
   ewma_pkg::s2_type s2_ff, s2_in;
   ewma_pkg::s3_type s3_ff, s3_in;
   ewma_pkg::s4_type s4_ff, s4_in;
   logic [ewma_pkg::PWR_W-1:0] rsp_power_ff, used_in;

   assign ready_out = !rsp_valid_ff || !rsp_stall;
   assign ready4    = !v4_ff || ready_out;
   assign ready3    = !v3_ff || ready4;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign wr_en     = v4_ff && ready_out;

   // a channel in flight blocks a new item for it until the write-back edge,
   // where the read is forwarded from the write data
   assign hazard = (v1_ff && s1_ff.ch == req_control_type) ||
                   (v2_ff && s2_ff.ch == req_control_type) ||
                   (v3_ff && s3_ff.ch == req_control_type) ||
                   (v4_ff && s4_ff.ch == req_control_type && !ready_out);

   assign req_stall = !ready1 || hazard;
   assign accept    = req_valid && !req_stall;

   assign v1_in        = ready1    ? accept : v1_ff;
   assign v2_in        = ready2    ? v1_ff  : v2_ff;
   assign v3_in        = ready3    ? v2_ff  : v3_ff;
   assign v4_in        = ready4    ? v3_ff  : v4_ff;
   assign rsp_valid_in = ready_out ? v4_ff  : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // history memory and per-channel flags
   ewma_pkg::hist_type hist_mem [ewma_pkg::NUM_TYPES];
   ewma_pkg::hist_type rd_ff, wr_data;
   logic [ewma_pkg::NUM_TYPES-1:0] hist_valid_ff;

   assign wr_data.ewma = s4_ff.ewma;
   assign wr_data.used = used_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[s4_ff.ch] <= wr_data;
      end
      if (accept) begin
         rd_ff <= (wr_en && s4_ff.ch == req_control_type) ? wr_data
                                                         : hist_mem[req_control_type];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
      end else if (wr_en) begin
         hist_valid_ff[s4_ff.ch] <= 1'b1;
      end
   end

   // stage 0: seed midpoint and clamped limit span
   logic [ewma_pkg::PWR_W:0] lim_sum;
   always_comb begin
      lim_sum    = {1'b0, req_max_limit} + {1'b0, req_min_limit};
      s1_in.ch   = req_control_type;
      s1_in.cur  = req_current_power;
      s1_in.mid  = lim_sum[ewma_pkg::PWR_W:1];
      s1_in.span = (req_max_limit >= req_min_limit) ? (req_max_limit - req_min_limit) : '0;
   end

   // stage 1: pick the history or the seed, form the weighted products
   logic [ewma_pkg::PWR_W-1:0] prev1;
   logic                       hv1;
   always_comb begin
      hv1   = hist_valid_ff[s1_ff.ch];
      prev1 = hv1 ? rd_ff.used : (seed_enable_ff ? seed_power_ff : s1_ff.mid);
      s2_in.ch         = s1_ff.ch;
      s2_in.cur        = s1_ff.cur;
      s2_in.prev_used  = rd_ff.used;
      s2_in.prev_ewma  = rd_ff.ewma;
      s2_in.hist_valid = hv1;
      s2_in.pa = ewma_pkg::PROD_W'(alpha_sat) * ewma_pkg::PROD_W'(s1_ff.cur);
      s2_in.pb = ewma_pkg::PROD_W'(ewma_pkg::PCT_FULL - alpha_sat) *
                 ewma_pkg::PROD_W'(prev1);
      s2_in.pd = ewma_pkg::PROD_W'(delta_sat) * ewma_pkg::PROD_W'(s1_ff.span);
   end

   // stage 2: weighted sum, drop from the last output
   logic [ewma_pkg::PWR_W:0] drop2;
   always_comb begin
      drop2 = {1'b0, s2_ff.prev_used} - {1'b0, s2_ff.cur};
      s3_in.ch         = s2_ff.ch;
      s3_in.cur        = s2_ff.cur;
      s3_in.prev_used  = s2_ff.prev_used;
      s3_in.prev_ewma  = s2_ff.prev_ewma;
      s3_in.hist_valid = s2_ff.hist_valid;
      s3_in.sum        = s2_ff.pa + s2_ff.pb;
      s3_in.pd         = s2_ff.pd;
      s3_in.ge         = !drop2[ewma_pkg::PWR_W];
      s3_in.diff       = drop2[ewma_pkg::PWR_W-1:0];
   end

   // stage 3: divide both by 100 through the reciprocal
   logic [ewma_pkg::QPROD_W-1:0] q_ewma, q_chg;
   always_comb begin
      q_ewma = ewma_pkg::QPROD_W'(s3_ff.sum) * ewma_pkg::QPROD_W'(ewma_pkg::RECIP);
      q_chg  = ewma_pkg::QPROD_W'(s3_ff.pd)  * ewma_pkg::QPROD_W'(ewma_pkg::RECIP);
      s4_in.ch         = s3_ff.ch;
      s4_in.cur        = s3_ff.cur;
      s4_in.prev_used  = s3_ff.prev_used;
      s4_in.prev_ewma  = s3_ff.prev_ewma;
      s4_in.hist_valid = s3_ff.hist_valid;
      s4_in.ge         = s3_ff.ge;
      s4_in.diff       = s3_ff.diff;
      s4_in.ewma       = q_ewma[ewma_pkg::RECIP_SHIFT +: ewma_pkg::PWR_W];
      s4_in.chg        = q_chg[ewma_pkg::RECIP_SHIFT +: ewma_pkg::PWR_W];
   end

   // stage 4: output selection
   logic [ewma_pkg::PWR_W:0] avg_sum;
   always_comb begin
      avg_sum = {1'b0, s4_ff.cur} + {1'b0, s4_ff.ewma};
      if (!s4_ff.hist_valid) begin
         used_in = (s4_ff.cur > s4_ff.ewma) ? s4_ff.cur : s4_ff.ewma;
      end else if (s4_ff.cur < s4_ff.ewma) begin
         // falling: limit the drop to the allowed change
         used_in = (s4_ff.ge && s4_ff.diff >= s4_ff.chg) ? (s4_ff.prev_used - s4_ff.chg)
                                                         : s4_ff.cur;
      end else if (s4_ff.cur > s4_ff.prev_ewma) begin
         used_in = avg_sum[ewma_pkg::PWR_W:1];
      end else begin
         used_in = s4_ff.cur;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1)    s1_ff        <= s1_in;
      if (ready2)    s2_ff        <= s2_in;
      if (ready3)    s3_ff        <= s3_in;
      if (ready4)    s4_ff        <= s4_in;
      if (ready_out) rsp_power_ff <= used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_power_used = rsp_power_ff;

   // no two items of one channel in flight at once, checked on stages 1 and 2 and on stages 2 and 4
   a_one_per_channel: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff) |-> (s1_ff.ch != s2_ff.ch))
      else $error("two items of one channel in stages 1 and 2");

   a_one_per_channel_late: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && v4_ff) |-> (s2_ff.ch != s4_ff.ch))
      else $error("two items of one channel in stages 2 and 4");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted item lost before stage 1");

   a_writeback_flag: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> hist_valid_ff[$past(s4_ff.ch)])
      else $error("history flag not set after write-back");

endmodule

`default_nettype wire

// File: bench/ewma_power_filter_slew_limited_checker.sv
`default_nettype none

module ewma_power_filter_slew_limited_checker
   import ewma_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_stall,
   input  wire [TYPE_W-1:0]     req_control_type,
   input  wire [PWR_W-1:0]      req_current_power,
   input  wire [PWR_W-1:0]      req_max_limit,
   input  wire [PWR_W-1:0]      req_min_limit,
   input  wire                  rsp_valid,
   input  wire                  rsp_stall,
   input  wire [PWR_W-1:0]      rsp_power_used,
   input  wire                  csr_write_enable,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_W-1:0]      csr_write_data,
   output int                   mismatches,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [TYPE_W-1:0] ch;
      logic [PWR_W-1:0]  power;
   } power_used_type;

   power_used_type power_used_q[$];

   logic [PCT_W-1:0] alpha;
   logic [PCT_W-1:0] delta;
   logic [PWR_W-1:0] seed;
   logic             seed_on;

   logic [PWR_W-1:0] hist_used [NUM_TYPES];
   logic [PWR_W-1:0] hist_ewma [NUM_TYPES];
   logic             hist_seen [NUM_TYPES];

   int errs = 0;

   function automatic logic [PWR_W-1:0] weighted_avg(input logic [63:0] a,
         input logic [PWR_W-1:0] cur, input logic [PWR_W-1:0] prev);
      logic [63:0] acc;
      acc = a * cur + (64'd100 - a) * prev;
      acc = acc / 64'd100;
      return acc[PWR_W-1:0];
   endfunction

   // predicts one filtered sample and advances that channel's history
   function automatic logic [PWR_W-1:0] filter_sample(input logic [TYPE_W-1:0] ch,
         input logic [PWR_W-1:0] cur, input logic [PWR_W-1:0] mx,
         input logic [PWR_W-1:0] mn);
      logic [63:0]      a;
      logic [63:0]      d;
      logic [63:0]      span;
      logic [63:0]      step;
      logic [63:0]      sum;
      logic [PWR_W-1:0] ewma;
      logic [PWR_W-1:0] used;
      logic [PWR_W-1:0] prev_used;
      logic [PWR_W-1:0] prev_ewma;
      a = (alpha > PCT_FULL) ? PCT_FULL : alpha;
      d = (delta > PCT_FULL) ? PCT_FULL : delta;
      prev_used = hist_used[ch];
      prev_ewma = hist_ewma[ch];
      if (!hist_seen[ch]) begin
         sum = mx;
         sum = sum + mn;
         ewma = weighted_avg(a, cur, seed_on ? seed : sum[PWR_W:1]);
         used = (cur > ewma) ? cur : ewma;
      end else begin
         ewma = weighted_avg(a, cur, prev_used);
         if (cur < ewma) begin
            span = (mx >= mn) ? mx - mn : 64'd0;
            step = d * span;
            step = step / 64'd100;
            if (prev_used >= cur && prev_used - cur >= step)
               used = prev_used - step[PWR_W-1:0];
            else
               used = cur;
         end else if (cur > prev_ewma) begin
            sum = cur;
            sum = sum + ewma;
            used = sum[PWR_W:1];
         end else begin
            used = cur;
         end
      end
      hist_used[ch] = used;
      hist_ewma[ch] = ewma;
      hist_seen[ch] = 1'b1;
      return used;
   endfunction

   always @(posedge clock) begin
      power_used_type want;
      if (reset) begin
         alpha   = ALPHA_RESET;
         delta   = DELTA_RESET;
         seed    = '0;
         seed_on = 1'b0;
         for (int i = 0; i < NUM_TYPES; i++) begin
            hist_used[i] = '0;
            hist_ewma[i] = '0;
            hist_seen[i] = 1'b0;
         end
         power_used_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (power_used_q.size() == 0) begin
               if (errs < 10)
                  $display("%t: result %0d with no item outstanding", $realtime,
                           rsp_power_used);
               errs++;
            end else begin
               want = power_used_q.pop_front();
               if (rsp_power_used !== want.power) begin
                  if (errs < 10)
                     $display("%t: ch %0d power_used expected %0d got %0d", $realtime,
                              want.ch, want.power, rsp_power_used);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want.ch    = req_control_type;
            want.power = filter_sample(req_control_type, req_current_power,
                                       req_max_limit, req_min_limit);
            power_used_q.push_back(want);
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ALPHA:       alpha   = csr_write_data[PCT_W-1:0];
               CSR_DELTA:       delta   = csr_write_data[PCT_W-1:0];
               CSR_SEED_POWER:  seed    = csr_write_data[PWR_W-1:0];
               CSR_SEED_ENABLE: seed_on = csr_write_data[0];
               default: ;
            endcase
         end
      end
      mismatches  <= errs;
      outstanding <= power_used_q.size();
   end

endmodule

`default_nettype wire

// File: bench/ewma_power_filter_slew_limited_tb.sv
`default_nettype none

module ewma_power_filter_slew_limited_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ewma_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 138;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [TYPE_W-1:0]    req_control_type = '0;
   logic [PWR_W-1:0]     req_current_power = '0;
   logic [PWR_W-1:0]     req_max_limit = '0;
   logic [PWR_W-1:0]     req_min_limit = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PWR_W-1:0]     rsp_power_used;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   int mismatches;
   int outstanding;
   int pace = 1;
   int stall_left = 0;
   int quiet = 0;

   logic [PWR_W-1:0] ch_max [NUM_TYPES];
   logic [PWR_W-1:0] ch_min [NUM_TYPES];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ewma_power_filter_slew_limited i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_control_type  (req_control_type),
      .req_current_power (req_current_power),
      .req_max_limit     (req_max_limit),
      .req_min_limit     (req_min_limit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_power_used    (rsp_power_used),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   ewma_power_filter_slew_limited_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_control_type  (req_control_type),
      .req_current_power (req_current_power),
      .req_max_limit     (req_max_limit),
      .req_min_limit     (req_min_limit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_power_used    (rsp_power_used),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   // pace 0 means no idling; higher pace gives more and longer gaps
   function automatic int idle_len();
      int r;
      if (pace == 0)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 100 - 12 * pace)
         return 0;
      if (r < 100 - 2 * pace)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PWR_W-1:0] rand_power();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return PWR_W'($urandom_range(0, 255));
         default: return PWR_W'($urandom);
      endcase
   endfunction

   function automatic logic [PCT_W-1:0] rand_pct();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return PCT_FULL;
         2:       return '1;
         3:       return PCT_W'($urandom_range(0, 127));
         default: return PCT_W'($urandom_range(0, 100));
      endcase
   endfunction

   always @(posedge clock) begin
      int n;
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         n = idle_len();
         rsp_stall  <= (n != 0);
         stall_left <= (n != 0) ? n - 1 : 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet == WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_sample(input logic [TYPE_W-1:0] ch, input logic [PWR_W-1:0] cur,
         input logic [PWR_W-1:0] mx, input logic [PWR_W-1:0] mn);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_control_type  <= ch;
      req_current_power <= cur;
      req_max_limit     <= mx;
      req_min_limit     <= mn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold off until every result is back and the pipeline has emptied
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   // upper data bits of the narrow registers carry junk that must be ignored
   task automatic write_config(input logic [PCT_W-1:0] alpha, input logic [PCT_W-1:0] delta,
         input logic [PWR_W-1:0] seed, input logic seed_on);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ALPHA;
      csr_write_data   <= {(CSR_W-PCT_W)'($urandom), alpha};
      @(posedge clock);
      csr_index        <= CSR_DELTA;
      csr_write_data   <= {(CSR_W-PCT_W)'($urandom), delta};
      @(posedge clock);
      csr_index        <= CSR_SEED_POWER;
      csr_write_data   <= seed;
      @(posedge clock);
      csr_index        <= CSR_SEED_ENABLE;
      csr_write_data   <= {(CSR_W-1)'($urandom), seed_on};
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random();
      logic [TYPE_W-1:0] ch;
      logic [PWR_W-1:0]  cur;
      logic [PWR_W-1:0]  t;
      ch = TYPE_W'($urandom_range(0, NUM_TYPES - 1));
      if ($urandom_range(0, 15) == 0) begin
         ch_max[ch] = rand_power();
         ch_min[ch] = rand_power();
         // mostly ordered limits, some inverted
         if (ch_min[ch] > ch_max[ch] && $urandom_range(0, 4) != 0) begin
            t          = ch_max[ch];
            ch_max[ch] = ch_min[ch];
            ch_min[ch] = t;
         end
      end
      case ($urandom_range(0, 7))
         0:       cur = ch_max[ch];
         1:       cur = ch_min[ch] + PWR_W'($urandom_range(0, 15));
         default: cur = rand_power();
      endcase
      send_sample(ch, cur, ch_max[ch], ch_min[ch]);
   endtask

   initial begin
      for (int i = 0; i < NUM_TYPES; i++) begin
         ch_max[i] = PWR_W'($urandom_range(500000, 1048575));
         ch_min[i] = PWR_W'($urandom_range(0, 400000));
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: midpoint seeding on channels 0 and 1
      send_sample(0, 20'd0, 20'd0, 20'd0);
      send_sample(1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      send_sample(0, 20'd1000, 20'd5000, 20'd3000);
      send_sample(1, 20'd0, 20'd0, 20'hFFFFF);
      send_sample(0, 20'hFFFFF, 20'hFFFFF, 20'd0);
      send_sample(0, 20'd0, 20'hFFFFF, 20'd0);
      send_sample(0, 20'd10, 20'hFFFFF, 20'd0);
      send_sample(1, 20'd7, 20'd10, 20'd20);
      settle();

      // saturated weights, seed at full scale
      write_config('1, '1, 20'hFFFFF, 1'b1);
      send_sample(2, 20'd5, 20'd100, 20'd50);
      send_sample(2, 20'd0, 20'hFFFFF, 20'd0);
      send_sample(2, 20'hFFFFF, 20'hFFFFF, 20'd0);
      send_sample(2, 20'h80000, 20'hFFFFF, 20'h7FFFF);
      settle();

      // alpha 0 keeps the history, delta 0 freezes falling output
      write_config('0, '0, 20'h5A5A5, 1'b1);
      send_sample(3, 20'hA5A5A, 20'hFFFFF, 20'd0);
      send_sample(3, 20'd0, 20'hFFFFF, 20'd0);
      send_sample(3, 20'hFFFFF, 20'hFFFFF, 20'd0);
      send_sample(1, 20'h12345, 20'hFFFFF, 20'd0);
      settle();

      write_config(PCT_FULL, PCT_FULL, 20'd0, 1'b0);
      send_sample(0, 20'h00001, 20'hFFFFF, 20'd0);
      send_sample(0, 20'hFFFFE, 20'hFFFFF, 20'd0);
      send_sample(3, 20'd3, 20'hFFFFF, 20'd0);
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         pace = p % 4;
         write_config(rand_pct(), rand_pct(), rand_power(), 1'($urandom_range(0, 1)));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 3 && i == PHASE_ITEMS / 2)
               settle();
            send_random();
         end
         settle();
      end

      if (mismatches == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
hdl/ewma_pkg.sv
hdl/ewma_power_filter_slew_limited.sv
bench/ewma_power_filter_slew_limited_checker.sv
bench/ewma_power_filter_slew_limited_tb.sv
